// ===== rtl/fvc_pkg.sv =====
// Shared types and constants for the FIFO vertex cache miss counter.
`timescale 1ns / 1ps
`default_nettype none

package fvc_pkg;

  localparam int CACHE_DEPTH_DEFAULT = 32;

  localparam int VIDX_W     = 32;
  localparam int MISS_W     = 32;
  localparam int CFG_W      = 6;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 40;

  localparam logic [CFG_W-1:0]  CACHE_ENTRIES_RESET = CFG_W'(32);
  localparam logic [MISS_W-1:0] MISS_MAX            = '1;

  // controller -> datapath
  typedef struct packed {
    logic start;   // input transaction taken, latch payload, clear scan
    logic step;    // read next cache entry
    logic update;  // apply miss handling and load the output register
  } fvc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_zero;  // cache holds no entries
    logic scan_last;  // entry being read is the last filled one
    logic out_free;   // output register can take a result
  } fvc_status_t;

endpackage

`default_nettype wire

// ===== rtl/fvc_datapath.sv =====
// Datapath: tag memory, scan compare, fill/oldest pointers, miss total, output register.
`timescale 1ns / 1ps
`default_nettype none

module fvc_datapath #(
  parameter int CACHE_DEPTH = fvc_pkg::CACHE_DEPTH_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  fvc_pkg::fvc_cmd_t          cmd,
  output fvc_pkg::fvc_status_t             status,
  input  wire  [fvc_pkg::S_TDATA_W-1:0]    s_tdata,
  input  wire                              s_tlast,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [fvc_pkg::CFG_W-1:0]        cfg_data,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [fvc_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tlast
);
  import fvc_pkg::*;

  localparam int FCW = $clog2(CACHE_DEPTH + 1);
  localparam int AW  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int EW  = (FCW > CFG_W) ? FCW : CFG_W;

  logic [VIDX_W-1:0] mem [CACHE_DEPTH];

  logic [CFG_W-1:0]  cache_entries;
  logic [VIDX_W-1:0] idx;
  logic              last_in;
  logic [AW-1:0]     scan_addr;
  logic [VIDX_W-1:0] rd_data;
  logic              cmp_valid;
  logic              hit;
  logic [FCW-1:0]    fill_count;
  logic [AW-1:0]     oldest_slot;
  logic [MISS_W-1:0] miss_total;

  logic [EW-1:0]     cfg_ext;
  logic [EW-1:0]     size_min1;
  logic [EW-1:0]     size_w;
  logic [FCW-1:0]    size;
  logic              hit_now;
  logic [MISS_W-1:0] miss_total_next;
  logic [AW-1:0]     slot_base;
  logic [FCW-1:0]    slot_inc;
  logic [AW-1:0]     oldest_slot_next;
  logic              append;
  logic [AW-1:0]     wr_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_entries <= CACHE_ENTRIES_RESET;
    end else if (cfg_valid) begin
      cache_entries <= cfg_data;
    end
  end

  // effective size: zero counts as one, clamp to the built depth
  always_comb begin
    cfg_ext   = EW'(cache_entries);
    size_min1 = (cfg_ext == '0) ? EW'(1) : cfg_ext;
    size_w    = (size_min1 > EW'(CACHE_DEPTH)) ? EW'(CACHE_DEPTH) : size_min1;
    size      = FCW'(size_w);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx     <= s_tdata[VIDX_W-1:0];
      last_in <= s_tlast;
    end
  end

  // one entry read per step, compared in the cycle after
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_data <= mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
    end else begin
      cmp_valid <= cmd.step;
      if (cmd.start) begin
        scan_addr <= '0;
        hit       <= 1'b0;
      end else begin
        if (cmd.step) begin
          scan_addr <= scan_addr + AW'(1);
        end
        if (cmp_valid && (rd_data == idx)) begin
          hit <= 1'b1;
        end
      end
    end
  end

  assign hit_now = hit;

  always_comb begin
    miss_total_next = miss_total;
    if (!hit_now && (miss_total != MISS_MAX)) begin
      miss_total_next = miss_total + MISS_W'(1);
    end
    append    = (fill_count < size);
    slot_base = (FCW'(oldest_slot) >= fill_count) ? '0 : oldest_slot;
    slot_inc  = FCW'(slot_base) + FCW'(1);
    oldest_slot_next = (slot_inc >= fill_count) ? '0 : slot_inc[AW-1:0];
    wr_addr   = append ? fill_count[AW-1:0] : slot_base;
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !hit_now) begin
      mem[wr_addr] <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      oldest_slot <= '0;
      miss_total  <= '0;
    end else if (cmd.update) begin
      if (last_in) begin
        fill_count  <= '0;
        oldest_slot <= '0;
        miss_total  <= '0;
      end else begin
        miss_total <= miss_total_next;
        if (!hit_now) begin
          if (append) begin
            fill_count <= fill_count + FCW'(1);
          end else begin
            oldest_slot <= oldest_slot_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      m_tdata <= {{(M_TDATA_W - MISS_W - 1){1'b0}}, miss_total_next, hit_now};
      m_tlast <= last_in;
    end
  end

  always_comb begin
    status.fill_zero = (fill_count == '0);
    status.scan_last = ((FCW'(scan_addr) + FCW'(1)) == fill_count);
    status.out_free  = !m_tvalid || m_tready;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FCW'(CACHE_DEPTH))
    else $error("fill count beyond built depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    (FCW'(oldest_slot) < fill_count) || (oldest_slot == '0))
    else $error("oldest pointer outside filled entries");

  a_update_out: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> status.out_free)
    else $error("result loaded over a waiting one");

  a_update_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> m_tvalid)
    else $error("result not presented after update");

endmodule

`default_nettype wire

// ===== rtl/fvc_ctrl.sv =====
// Controller: sequences accept, tag scan and update for each transaction.
`timescale 1ns / 1ps
`default_nettype none

module fvc_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  fvc_pkg::fvc_status_t  status,
  output fvc_pkg::fvc_cmd_t           cmd
);
  import fvc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = status.fill_zero ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_WAIT;
        end
      end
      // last read entry is compared here
      ST_WAIT: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.step, cmd.update}))
    else $error("more than one datapath command at once");

  a_scan_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && !status.fill_zero) |=> cmd.step)
    else $error("scan did not begin after accept");

endmodule

`default_nettype wire

// ===== rtl/fifo_vertex_cache_miss_counter_core.sv =====
// Top level of the FIFO post-transform vertex cache miss counter.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = vertex_index; s_tlast = last_index
//  m_*       out  m_tvalid/m_tready  m_tdata = hit, miss_count; m_tlast = last
//  cfg_*     in   cfg_valid/ready    cfg_data = cache_entries
//
// An item goes straight from accept to update when the cache is empty; otherwise
// the tags sit in a single-port memory and are scanned first, one entry per cycle.
// Reset (rst, synchronous) empties the cache, clears the miss total and sets
// cache_entries to 32. The output register holds a result while m_tready is low;
// the next item is accepted meanwhile and its update waits for the register.
`timescale 1ns / 1ps
`default_nettype none

module fifo_vertex_cache_miss_counter_core #(
  parameter int CACHE_DEPTH = fvc_pkg::CACHE_DEPTH_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [fvc_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] vertex_index
  input  wire                            s_tlast,
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [fvc_pkg::M_TDATA_W-1:0]  m_tdata,   // [0] hit, [32:1] miss_count, rest zero
  output logic                           m_tlast,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [fvc_pkg::CFG_W-1:0]      cfg_data
);
  import fvc_pkg::*;

  fvc_cmd_t    cmd;
  fvc_status_t status;

  fvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fvc_datapath #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the FIFO vertex cache miss counter core.
`timescale 1ns / 1ps

module tb_top;
  import fvc_pkg::*;

  localparam int DEPTH       = CACHE_DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic [VIDX_W-1:0] vidx;
    logic              last;
  } vertex_item_t;

  typedef struct {
    logic              hit;
    logic [MISS_W-1:0] misses;
    logic              last;
  } lookup_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [VIDX_W-1:0] tag_mem [DEPTH];
  int                filled = 0;
  int                oldest = 0;
  logic [MISS_W-1:0] miss_total = '0;
  logic [CFG_W-1:0]  entries_cfg = CACHE_ENTRIES_RESET;

  vertex_item_t   pending_vertices[$];
  lookup_result_t expected_lookups[$];

  int mismatches = 0;
  int stall_cycles = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold = 0;
  int hold_req = 0;
  int hold_seen = 0;
  bit quiet = 1'b0;

  fifo_vertex_cache_miss_counter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [31:0] vertex_index
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [0] hit, [32:1] miss_count, [39:33] zero
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Looks one index up, updates the cache copy and returns the expected result.
  function automatic lookup_result_t lookup_vertex(logic [VIDX_W-1:0] vidx, logic last_flag);
    lookup_result_t r;
    int             size;
    int             slot;
    size  = (entries_cfg == 0) ? 1 : ((entries_cfg > DEPTH) ? DEPTH : int'(entries_cfg));
    r.hit = 1'b0;
    // all filled entries are compared, even after the size shrinks
    for (int i = 0; i < filled; i++)
      if (tag_mem[i] == vidx) r.hit = 1'b1;
    if (!r.hit) begin
      if (miss_total != MISS_MAX) miss_total = miss_total + 1'b1;
      if (filled < size) begin
        tag_mem[filled] = vidx;
        filled++;
      end else begin
        slot = (oldest >= filled) ? 0 : oldest;
        tag_mem[slot] = vidx;
        slot++;
        oldest = (slot >= filled) ? 0 : slot;
      end
    end
    r.misses = miss_total;
    r.last   = last_flag;
    if (last_flag) begin
      filled     = 0;
      oldest     = 0;
      miss_total = '0;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    vertex_item_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_lookups.insert(expected_lookups.size(),
                                lookup_vertex(s_tdata[VIDX_W-1:0], s_tlast));
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_vertices.size() != 0) begin
          item     = pending_vertices.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= item.vidx;
          s_tlast  <= item.last;
          if (!quiet && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and result checker
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: hit %0b misses %0d last %0b",
                     m_tdata[0], m_tdata[MISS_W:1], m_tlast);
        end else begin
          want = expected_lookups.pop_front();
          if (m_tdata[0] !== want.hit || m_tdata[MISS_W:1] !== want.misses ||
              m_tlast !== want.last || m_tdata[M_TDATA_W-1:MISS_W+1] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: hit exp %0b got %0b, misses exp %0d got %0d, ",
                        "last exp %0b got %0b, pad %h"},
                       want.hit, m_tdata[0], want.misses, m_tdata[MISS_W:1], want.last, m_tlast,
                       m_tdata[M_TDATA_W-1:MISS_W+1]);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        rx_hold   <= LONG_HOLD;
        m_tready  <= 1'b0;
      end else if (rx_hold != 0) begin
        rx_hold  <= rx_hold - 1;
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap   <= rx_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap   <= $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_vertex(logic [VIDX_W-1:0] vidx, logic last_flag);
    vertex_item_t item;
    item.vidx = vidx;
    item.last = last_flag;
    pending_vertices.insert(pending_vertices.size(), item);
  endtask

  // sender pauses until every expected result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_vertices.size() != 0 || s_tvalid || expected_lookups.size() != 0);
  endtask

  task automatic write_entries(logic [CFG_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid   <= 1'b0;
    entries_cfg = value;
  endtask

  initial begin
    logic [CFG_W-1:0]  cfg_pick;
    logic [VIDX_W-1:0] base;
    int                span;
    int                run;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extreme indices, hits on the last item, clear after last
    push_vertex(32'h0000_0000, 1'b0);
    push_vertex(32'h0000_0000, 1'b0);
    push_vertex(32'hFFFF_FFFF, 1'b0);
    push_vertex(32'hAAAA_AAAA, 1'b0);
    push_vertex(32'h5555_5555, 1'b0);
    push_vertex(32'hFFFF_FFFF, 1'b1);
    push_vertex(32'h0000_0007, 1'b1);
    push_vertex(32'h0000_0000, 1'b1);
    // zero size behaves as one entry
    write_entries(6'd0);
    push_vertex(32'd3, 1'b0);
    push_vertex(32'd3, 1'b0);
    push_vertex(32'd4, 1'b0);
    push_vertex(32'd3, 1'b0);
    push_vertex(32'd4, 1'b1);
    // oversize clamps to the built depth
    write_entries(6'd63);
    push_vertex(32'd5, 1'b0);
    push_vertex(32'd5, 1'b1);
    // two entries, wrap of the oldest pointer
    write_entries(6'd2);
    push_vertex(32'd1, 1'b0);
    push_vertex(32'd2, 1'b0);
    push_vertex(32'd1, 1'b0);
    push_vertex(32'd3, 1'b0);
    push_vertex(32'd1, 1'b0);
    // shrink mid-mesh: both filled entries still compared
    write_entries(6'd1);
    push_vertex(32'd1, 1'b0);
    push_vertex(32'd9, 1'b0);
    // grow mid-mesh: append resumes
    write_entries(6'd4);
    push_vertex(32'd10, 1'b0);
    push_vertex(32'd9, 1'b0);
    push_vertex(32'd11, 1'b1);

    // random phases, meshes may straddle a size change
    run = 0;
    base = '0;
    span = 1;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       cfg_pick = 6'd1;
        1:       cfg_pick = 6'd32;
        2:       cfg_pick = 6'd31;
        3:       cfg_pick = 6'd33;
        default: cfg_pick = CFG_W'($urandom_range(0, 63));
      endcase
      write_entries(cfg_pick);
      if (ph == 1) hold_req++;
      if (ph == 11) quiet = 1'b1;
      for (int k = 0; k < 40; k++) begin
        if (run == 0) begin
          run  = $urandom_range(1, 30);
          base = $urandom;
          span = $urandom_range(1, 70);
        end
        run--;
        if ($urandom_range(0, 9) == 0)
          push_vertex($urandom, run == 0);
        else
          push_vertex(base + $urandom_range(0, span), run == 0);
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_lookups.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
